FILE: hdl/i2c_master_byte_engine_unit_macros.svh
// Assertion macros for the I2C master byte engine.
// Included by the top level; no other dependencies.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define I2CMBE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c byte engine check failed");

`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c byte engine check failed");

`else

`define I2CMBE_ASSERT_IMPL(label, clk, rst, ante, cons)

`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/i2cmbe_pkg.sv
// Types and constants for the I2C master byte engine.
// No dependencies.
package i2cmbe_pkg;

   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_BIT    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD        = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACK_TIMEOUT = 2'd2;

   localparam logic [7:0] HALF_BIT_RESET    = 8'd2;
   localparam logic [7:0] HOLD_RESET        = 8'd4;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

   typedef enum logic {
      REQ_TICK    = 1'b0,
      REQ_COMMAND = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [13:0] {
      PH_IDLE    = 14'b00000000000001,
      PH_STA_A   = 14'b00000000000010,
      PH_STA_B   = 14'b00000000000100,
      PH_STO_A   = 14'b00000000001000,
      PH_STO_B   = 14'b00000000010000,
      PH_STO_C   = 14'b00000000100000,
      PH_WR_LOW  = 14'b00000001000000,
      PH_WR_HIGH = 14'b00000010000000,
      PH_WA_LOW  = 14'b00000100000000,
      PH_WA_HIGH = 14'b00001000000000,
      PH_RD_LOW  = 14'b00010000000000,
      PH_RD_HIGH = 14'b00100000000000,
      PH_RA_LOW  = 14'b01000000000000,
      PH_RA_HIGH = 14'b10000000000000
   } phase_type;

   // a zero register acts as one tick
   function automatic logic [7:0] tick_limit(input logic [7:0] r);
      return (r == 8'd0) ? 8'd1 : r;
   endfunction

endpackage

FILE: hdl/i2c_master_byte_engine_unit.sv
// Byte-level I2C master: sequencer, configuration registers, stream ports.
// Depends on i2cmbe_pkg and i2c_master_byte_engine_unit_macros.svh.
//
// Each request is a command (start, stop, write byte, read byte) or a tick
// carrying the sampled SDA level; every request yields exactly one response
// with the driven SCL/SDA levels and status. One request is accepted per
// clock while the response side does not stall; a request passes an input
// register, one step of the bit sequencer and the response register, and a
// stalled response holds the input register and blocks new requests.
// Commands sent while a command is in progress are ignored and flagged
// cmd_rejected. Bus timing counts ticks only, using half_bit_ticks,
// hold_ticks and ack_timeout.
`include "i2c_master_byte_engine_unit_macros.svh"

module i2c_master_byte_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] command, [9:2] tx_byte, [10] ack_after_read, [11] sda_in
   input  logic [i2cmbe_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
   // [11:4] rx_byte, [12] ack_failed, [13] cmd_rejected
   output logic [i2cmbe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                              csr_we,
   input  logic [i2cmbe_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [i2cmbe_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import i2cmbe_pkg::*;

   logic [7:0] half_bit_ff, hold_ff, ack_timeout_ff;

   logic         item_valid_ff;
   req_kind_type item_kind_ff;
   cmd_type      item_cmd_ff;
   logic [7:0]   item_tx_ff;
   logic         item_ackr_ff, item_sda_ff;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [7:0] wait_count_ff, wait_count_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       fail_pending_ff, fail_pending_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic       advance;
   logic       done_in, failed_in, rejected_in;
   logic [7:0] rx_in, tick_sum;
   logic [3:0] bit_sum;
   logic       hb_end, hold_end;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff    <= HALF_BIT_RESET;
         hold_ff        <= HOLD_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_BIT:    half_bit_ff    <= csr_wdata;
            CSR_HOLD:        hold_ff        <= csr_wdata;
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_kind_ff <= req_kind_type'(req_tuser);
         item_cmd_ff  <= cmd_type'(req_tdata[1:0]);
         item_tx_ff   <= req_tdata[9:2];
         item_ackr_ff <= req_tdata[10];
         item_sda_ff  <= req_tdata[11];
      end
   end

   // sequencer step
   always_comb begin
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      shift_in        = shift_ff;
      tick_count_in   = tick_count_ff;
      wait_count_in   = wait_count_ff;
      ack_choice_in   = ack_choice_ff;
      scl_in          = scl_ff;
      sda_in          = sda_ff;
      fail_pending_in = fail_pending_ff;
      done_in         = 1'b0;
      failed_in       = 1'b0;
      rejected_in     = 1'b0;
      rx_in           = 8'd0;
      tick_sum        = tick_count_ff + 8'd1;
      bit_sum         = bit_count_ff + 4'd1;
      hb_end          = tick_sum >= tick_limit(half_bit_ff);
      hold_end        = tick_sum >= tick_limit(hold_ff);

      if (item_kind_ff == REQ_COMMAND) begin
         if (phase_ff != PH_IDLE) begin
            rejected_in = 1'b1;
         end else begin
            tick_count_in   = 8'd0;
            bit_count_in    = 4'd0;
            fail_pending_in = 1'b0;
            unique case (item_cmd_ff)
               CMD_START: begin
                  sda_in = 1'b1; scl_in = 1'b1; phase_in = PH_STA_A;
               end
               CMD_STOP: begin
                  sda_in = 1'b0; scl_in = 1'b0; phase_in = PH_STO_A;
               end
               CMD_WRITE: begin
                  shift_in = item_tx_ff; scl_in = 1'b0;
                  sda_in = item_tx_ff[7]; phase_in = PH_WR_LOW;
               end
               CMD_READ: begin
                  shift_in = 8'd0; ack_choice_in = item_ackr_ff;
                  scl_in = 1'b0; sda_in = 1'b1; phase_in = PH_RD_LOW;
               end
               default: ;
            endcase
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: ;
            PH_STA_A: begin
               tick_count_in = hold_end ? 8'd0 : tick_sum;
               if (hold_end) begin
                  sda_in = 1'b0; phase_in = PH_STA_B;
               end
            end
            PH_STA_B: begin
               tick_count_in = hold_end ? 8'd0 : tick_sum;
               if (hold_end) begin
                  scl_in = 1'b0; phase_in = PH_IDLE; done_in = 1'b1;
               end
            end
            PH_STO_A: begin
               tick_count_in = hold_end ? 8'd0 : tick_sum;
               if (hold_end) begin
                  scl_in = 1'b1; phase_in = PH_STO_B;
               end
            end
            PH_STO_B: begin
               tick_count_in = hold_end ? 8'd0 : tick_sum;
               if (hold_end) begin
                  sda_in = 1'b1; phase_in = PH_STO_C;
               end
            end
            PH_STO_C: begin
               tick_count_in = hold_end ? 8'd0 : tick_sum;
               if (hold_end) begin
                  phase_in = PH_IDLE; done_in = 1'b1;
                  failed_in = fail_pending_ff; fail_pending_in = 1'b0;
               end
            end
            PH_WR_LOW: begin
               tick_count_in = hb_end ? 8'd0 : tick_sum;
               if (hb_end) begin
                  scl_in = 1'b1; phase_in = PH_WR_HIGH;
               end
            end
            PH_WR_HIGH: begin
               tick_count_in = hb_end ? 8'd0 : tick_sum;
               if (hb_end) begin
                  scl_in       = 1'b0;
                  bit_count_in = bit_sum;
                  if (bit_sum >= BITS_PER_BYTE) begin
                     sda_in = 1'b1; phase_in = PH_WA_LOW;
                  end else begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     sda_in   = shift_ff[6];
                     phase_in = PH_WR_LOW;
                  end
               end
            end
            PH_WA_LOW: begin
               tick_count_in = hb_end ? 8'd0 : tick_sum;
               if (hb_end) begin
                  scl_in = 1'b1; wait_count_in = 8'd0; phase_in = PH_WA_HIGH;
               end
            end
            PH_WA_HIGH: begin
               if (!item_sda_ff) begin
                  scl_in = 1'b0; phase_in = PH_IDLE; done_in = 1'b1;
               end else if (wait_count_ff >= ack_timeout_ff) begin
                  // no ack: force a stop and report it at its end
                  scl_in = 1'b0; sda_in = 1'b0; tick_count_in = 8'd0;
                  fail_pending_in = 1'b1; phase_in = PH_STO_A;
               end else begin
                  wait_count_in = wait_count_ff + 8'd1;
               end
            end
            PH_RD_LOW: begin
               tick_count_in = hb_end ? 8'd0 : tick_sum;
               if (hb_end) begin
                  scl_in = 1'b1; phase_in = PH_RD_HIGH;
               end
            end
            PH_RD_HIGH: begin
               tick_count_in = hb_end ? 8'd0 : tick_sum;
               if (hb_end) begin
                  shift_in     = {shift_ff[6:0], item_sda_ff};
                  scl_in       = 1'b0;
                  bit_count_in = bit_sum;
                  if (bit_sum >= BITS_PER_BYTE) begin
                     sda_in = !ack_choice_ff; phase_in = PH_RA_LOW;
                  end else begin
                     phase_in = PH_RD_LOW;
                  end
               end
            end
            PH_RA_LOW: begin
               tick_count_in = hb_end ? 8'd0 : tick_sum;
               if (hb_end) begin
                  scl_in = 1'b1; phase_in = PH_RA_HIGH;
               end
            end
            PH_RA_HIGH: begin
               tick_count_in = hb_end ? 8'd0 : tick_sum;
               if (hb_end) begin
                  scl_in = 1'b0; phase_in = PH_IDLE; done_in = 1'b1;
                  rx_in = shift_ff;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      rsp_data_in = {2'b00, rejected_in, failed_in, rx_in, done_in,
                     (phase_in != PH_IDLE), sda_in, scl_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bit_count_ff    <= 4'd0;
         shift_ff        <= 8'd0;
         tick_count_ff   <= 8'd0;
         wait_count_ff   <= 8'd0;
         ack_choice_ff   <= 1'b0;
         scl_ff          <= 1'b1;
         sda_ff          <= 1'b1;
         fail_pending_ff <= 1'b0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         shift_ff        <= shift_in;
         tick_count_ff   <= tick_count_in;
         wait_count_ff   <= wait_count_in;
         ack_choice_ff   <= ack_choice_in;
         scl_ff          <= scl_in;
         sda_ff          <= sda_in;
         fail_pending_ff <= fail_pending_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `I2CMBE_ASSERT_NEXT(a_reject_keeps_phase, clock, reset, advance && rejected_in, $stable(phase_ff))
   `I2CMBE_ASSERT_IMPL(a_done_ends_idle, clock, reset, advance && done_in, phase_in == PH_IDLE)
   `I2CMBE_ASSERT_IMPL(a_fail_with_done, clock, reset, rsp_valid_ff && rsp_data_ff[12], rsp_data_ff[3])
   `I2CMBE_ASSERT_IMPL(a_stall_blocks_input, clock, reset, item_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)

endmodule
